/* rtl/cpu_hog_watchdog_logger_assert.svh */
// Assertion macros shared by the watchdog logger RTL.
`ifndef CPU_HOG_WATCHDOG_LOGGER_ASSERT_SVH
`define CPU_HOG_WATCHDOG_LOGGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CHWL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHWL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/chwl_pkg.sv */
// Types and constants for the CPU hog watchdog logger.
`timescale 1ns / 1ps

package chwl_pkg;

    localparam int TIME_W  = 48;
    localparam int TASK_W  = 22;
    localparam int RIDX_W  = 8;
    localparam int COUNT_W = 9;
    localparam int CFG_W   = 48;

    localparam logic [TIME_W-1:0] THRESHOLD_RESET = 48'd50_000_000;

    typedef enum logic [1:0] {
        MODE_SWITCH = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_ENABLED   = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        mode_t              mode;
        logic [TIME_W-1:0]  now_time;
        logic [TASK_W-1:0]  task_id;
        logic               idle_or_alone;
        logic [RIDX_W-1:0]  read_index;
    } item_t;

    typedef struct packed {
        logic               logged;
        logic [COUNT_W-1:0] record_count;
        logic               read_valid;
        logic [TASK_W-1:0]  read_task;
        logic [TIME_W-1:0]  read_duration;
    } result_t;

    // record table write controls (address travels separately)
    typedef struct packed {
        logic               task_we;
        logic               dur_we;
        logic [TASK_W-1:0]  task_val;
        logic [TIME_W-1:0]  dur_val;
    } wr_ctl_t;

endpackage

/* rtl/chwl_rec_mem.sv */
// Record table: task and duration memories with registered read and write bypass.
`timescale 1ns / 1ps

module chwl_rec_mem #(
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  chwl_pkg::wr_ctl_t                    wr,
    output logic [chwl_pkg::TASK_W-1:0]          rd_task,
    output logic [chwl_pkg::TIME_W-1:0]          rd_dur
);

    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic [chwl_pkg::TASK_W-1:0] task_mem [DEPTH];
    logic [chwl_pkg::TIME_W-1:0] dur_mem  [DEPTH];

    logic [ADDR_W-1:0]           rd_addr_reg;
    logic [chwl_pkg::TASK_W-1:0] rd_task_reg;
    logic [chwl_pkg::TIME_W-1:0] rd_dur_reg;

    // last write per table, for a read issued on the same edge as that write
    logic                        byp_task_valid_reg;
    logic                        byp_dur_valid_reg;
    logic [ADDR_W-1:0]           byp_task_addr_reg;
    logic [ADDR_W-1:0]           byp_dur_addr_reg;
    logic [chwl_pkg::TASK_W-1:0] byp_task_reg;
    logic [chwl_pkg::TIME_W-1:0] byp_dur_reg;

    always_ff @(posedge clk)
    begin
        if (wr.task_we)
        begin
            task_mem[wr_addr] <= wr.task_val;
        end
        if (wr.dur_we)
        begin
            dur_mem[wr_addr] <= wr.dur_val;
        end
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
            rd_task_reg <= task_mem[rd_addr];
            rd_dur_reg  <= dur_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.task_we)
        begin
            byp_task_addr_reg <= wr_addr;
            byp_task_reg      <= wr.task_val;
        end
        if (wr.dur_we)
        begin
            byp_dur_addr_reg <= wr_addr;
            byp_dur_reg      <= wr.dur_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_task_valid_reg <= 1'b0;
            byp_dur_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr.task_we)
            begin
                byp_task_valid_reg <= 1'b1;
            end
            if (wr.dur_we)
            begin
                byp_dur_valid_reg <= 1'b1;
            end
        end
    end

    assign rd_task = (byp_task_valid_reg && byp_task_addr_reg == rd_addr_reg) ?
                     byp_task_reg : rd_task_reg;
    assign rd_dur  = (byp_dur_valid_reg && byp_dur_addr_reg == rd_addr_reg) ?
                     byp_dur_reg : rd_dur_reg;

endmodule

/* rtl/chwl_core.sv */
// Watchdog state, configuration registers and per-word decision logic.
`timescale 1ns / 1ps

module chwl_core #(
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [chwl_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 fire,
    input  chwl_pkg::item_t                      item,
    input  logic [chwl_pkg::TASK_W-1:0]          rd_task,
    input  logic [chwl_pkg::TIME_W-1:0]          rd_dur,
    output chwl_pkg::result_t                    res,
    output chwl_pkg::wr_ctl_t                    wr,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr
);

    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = CNT_W > chwl_pkg::RIDX_W ? CNT_W : chwl_pkg::RIDX_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic                          enabled_reg,   enabled_next;
    logic [chwl_pkg::TIME_W-1:0]   threshold_reg, threshold_next;
    logic [chwl_pkg::TIME_W-1:0]   last_time_reg, last_time_next;
    logic                          seeded_reg,    seeded_next;
    logic                          pending_reg,   pending_next;
    logic [CNT_W-1:0]              used_reg,      used_next;
    logic [chwl_pkg::TIME_W-1:0]   run_len;

    always_comb
    begin
        enabled_next   = enabled_reg;
        threshold_next = threshold_reg;
        last_time_next = last_time_reg;
        seeded_next    = seeded_reg;
        pending_next   = pending_reg;
        used_next      = used_reg;
        res            = '0;
        wr             = '0;
        wr_addr        = ADDR_W'(used_reg);
        run_len        = item.now_time - last_time_reg;   // wraps at 48 bits

        if (fire)
        begin
            unique case (item.mode)
                chwl_pkg::MODE_SWITCH, chwl_pkg::MODE_TICK:
                begin
                    if (enabled_reg)
                    begin
                        if (!seeded_reg)
                        begin
                            last_time_next = item.now_time;
                            seeded_next    = 1'b1;
                        end
                        else if (item.mode == chwl_pkg::MODE_SWITCH)
                        begin
                            last_time_next = item.now_time;
                            if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                // stretch the open record to the full run
                                if (used_reg != '0)
                                begin
                                    wr.dur_we  = 1'b1;
                                    wr.dur_val = run_len;
                                    wr_addr    = ADDR_W'(used_reg - CNT_W'(1));
                                end
                            end
                        end
                        else if (item.idle_or_alone)
                        begin
                            last_time_next = item.now_time;
                        end
                        else if (!pending_reg && run_len >= threshold_reg &&
                                 used_reg != FULL)
                        begin
                            wr.task_we   = 1'b1;
                            wr.dur_we    = 1'b1;
                            wr.task_val  = item.task_id;
                            wr.dur_val   = run_len;
                            used_next    = used_reg + CNT_W'(1);
                            pending_next = 1'b1;
                            res.logged   = 1'b1;
                        end
                    end
                end
                chwl_pkg::MODE_READ:
                begin
                    if (CMP_W'(item.read_index) < CMP_W'(used_reg))
                    begin
                        res.read_valid    = 1'b1;
                        res.read_task     = rd_task;
                        res.read_duration = rd_dur;
                    end
                end
                chwl_pkg::MODE_NONE:
                begin
                end
            endcase
        end

        if (cfg_we)
        begin
            unique case (chwl_pkg::cfg_idx_t'(cfg_index))
                chwl_pkg::CFG_ENABLED:
                begin
                    enabled_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        seeded_next  = 1'b0;
                        pending_next = 1'b0;
                    end
                end
                chwl_pkg::CFG_THRESHOLD:
                begin
                    threshold_next = cfg_data;
                end
            endcase
        end

        res.record_count = chwl_pkg::COUNT_W'(used_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            threshold_reg <= chwl_pkg::THRESHOLD_RESET;
            last_time_reg <= '0;
            seeded_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            threshold_reg <= threshold_next;
            last_time_reg <= last_time_next;
            seeded_reg    <= seeded_next;
            pending_reg   <= pending_next;
            used_reg      <= used_next;
        end
    end

endmodule

/* rtl/cpu_hog_watchdog_logger.sv */
// CPU hog watchdog logger: top level with input and output word registers.
// An accepted word is held in the input register until its result fills the output register.
// Throughput: one word per cycle unless m_tready stalls the output; the input register, the
// core logic and the output register run as one pass, with the record memory read at accept.
// Reset (rst_n, async, active low): disabled, threshold 50,000,000 ns, no records,
// both stages empty; the record memory is not cleared.
`timescale 1ns / 1ps

module cpu_hog_watchdog_logger #(
    parameter int RECORD_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [47:0] now_time, [69:48] task_id, [70] idle_or_alone, [78:71] read_index, [79] zero
    input  logic [79:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] logged, [9:1] record_count, [10] read_valid, [32:11] read_task,
    // [80:33] read_duration, [87:81] zero
    output logic [87:0] m_tdata
);

    localparam int ADDR_W = RECORD_DEPTH > 1 ? $clog2(RECORD_DEPTH) : 1;

    chwl_pkg::item_t   in_item_reg, in_item_next;
    logic              in_valid_reg, in_valid_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [87:0]       m_tdata_reg, m_tdata_next;

    logic              advance;
    logic              fire;
    logic              accept;
    chwl_pkg::result_t core_res;
    chwl_pkg::wr_ctl_t wr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [chwl_pkg::TASK_W-1:0] rd_task;
    logic [chwl_pkg::TIME_W-1:0] rd_dur;

    assign advance  = !m_tvalid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = ADDR_W'(s_tdata[78:71]);

    always_comb
    begin
        in_item_next.mode          = chwl_pkg::mode_t'(s_tuser);
        in_item_next.now_time      = s_tdata[47:0];
        in_item_next.task_id       = s_tdata[69:48];
        in_item_next.idle_or_alone = s_tdata[70];
        in_item_next.read_index    = s_tdata[78:71];

        in_valid_next = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        m_tvalid_next = fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = {7'b0, core_res.read_duration, core_res.read_task,
                         core_res.read_valid, core_res.record_count, core_res.logged};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_item_next;
        end
        if (fire)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    chwl_core #(
        .DEPTH (RECORD_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (in_item_reg),
        .rd_task   (rd_task),
        .rd_dur    (rd_dur),
        .res       (core_res),
        .wr        (wr),
        .wr_addr   (wr_addr)
    );

    chwl_rec_mem #(
        .DEPTH (RECORD_DEPTH)
    ) u_rec_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_task (rd_task),
        .rd_dur  (rd_dur)
    );

`include "cpu_hog_watchdog_logger_assert.svh"

    `CHWL_ASSERT_NEXT(a_fire_gives_result, fire, m_tvalid_reg, "processed word gave no result")
    `CHWL_ASSERT_NEXT(a_stage_holds, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg), "stalled input word lost or changed")
    `CHWL_ASSERT_NOW(a_log_counts, fire && core_res.logged,
        core_res.record_count != '0 && !core_res.read_valid, "logged word with bad count")

endmodule
